// ===== hw/rtl/uks_pkg.sv =====
// Package for the unique-key stack: field widths, operation and status codes,
// and the result word type passed from the controller to the output stage.
// No dependencies.
package uks_pkg;

  localparam int unsigned DEF_STACK_DEPTH = 16;
  localparam int unsigned KEY_W           = 32;
  localparam int unsigned DATA_W          = 32;
  localparam int unsigned COUNT_W         = 5;
  localparam int unsigned MODE_W          = 2;

  typedef logic [MODE_W-1:0] mode_t;

  localparam mode_t MODE_PUSH = 2'd0;
  localparam mode_t MODE_POP  = 2'd1;
  localparam mode_t MODE_PEEK = 2'd2;

  typedef enum logic [1:0] {
    ST_OK    = 2'd0,
    ST_DUP   = 2'd1,
    ST_UNDER = 2'd2,
    ST_OVER  = 2'd3
  } status_e;

  typedef struct packed {
    logic [COUNT_W-1:0] entry_count;
    logic               is_empty;
    logic [DATA_W-1:0]  out_data;
    logic [KEY_W-1:0]   out_key;
    status_e            status;
  } res_t;

endpackage

// ===== hw/rtl/uks_mem.sv =====
// Single-port-write, single-port-read synchronous memory holding key and data
// pairs, with a registered read: the data appears in the cycle after the address.
// Depends on nothing.
module uks_mem #(
  parameter int unsigned DEPTH  = 16,
  parameter int unsigned ADDR_W = $clog2(DEPTH),
  parameter int unsigned WORD_W = 64
) (
  input  logic              clk_i,
  input  logic              we_i,
  input  logic [ADDR_W-1:0] waddr_i,
  input  logic [WORD_W-1:0] wdata_i,
  input  logic [ADDR_W-1:0] raddr_i,
  output logic [WORD_W-1:0] rdata_o
);

  logic [WORD_W-1:0] mem_q [DEPTH];
  logic [WORD_W-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    rdata_q <= mem_q[raddr_i];
  end

  assign rdata_o = rdata_q;

endmodule

// ===== hw/rtl/uks_ctrl.sv =====
// Sequencer of the unique-key stack: duplicate search over the stored keys,
// push, pop and peek, and the fill level. Drives the pair memory.
// Depends on uks_pkg.
module uks_ctrl #(
  parameter int unsigned STACK_DEPTH = uks_pkg::DEF_STACK_DEPTH,
  parameter int unsigned ADDR_W      = $clog2(STACK_DEPTH),
  parameter int unsigned FILL_W      = $clog2(STACK_DEPTH + 1)
) (
  input  logic                                     clk_i,
  input  logic                                     rst_ni,
  input  logic                                     in_valid_i,
  output logic                                     in_ready_o,
  input  uks_pkg::mode_t                           mode_i,
  input  logic [uks_pkg::KEY_W-1:0]                key_i,
  input  logic [uks_pkg::DATA_W-1:0]               data_i,
  output logic                                     res_valid_o,
  input  logic                                     res_ready_i,
  output uks_pkg::res_t                            res_o,
  output logic                                     mem_we_o,
  output logic [ADDR_W-1:0]                        mem_waddr_o,
  output logic [uks_pkg::DATA_W+uks_pkg::KEY_W-1:0] mem_wdata_o,
  output logic [ADDR_W-1:0]                        mem_raddr_o,
  input  logic [uks_pkg::DATA_W+uks_pkg::KEY_W-1:0] mem_rdata_i
);
  import uks_pkg::*;

  typedef enum logic [3:0] {
    S_IDLE   = 4'b0001,
    S_SEARCH = 4'b0010,
    S_READ   = 4'b0100,
    S_RESP   = 4'b1000
  } state_e;

  state_e             state_q, state_d;
  logic [FILL_W-1:0]  fill_q, fill_d;
  logic [ADDR_W-1:0]  cnt_q, cnt_d;
  mode_t              mode_q, mode_d;
  logic [KEY_W-1:0]   key_q, key_d;
  logic [DATA_W-1:0]  data_q, data_d;
  status_e            status_q, status_d;
  logic [KEY_W-1:0]   okey_q, okey_d;
  logic [DATA_W-1:0]  odata_q, odata_d;

  logic [KEY_W-1:0]   rd_key;
  logic [DATA_W-1:0]  rd_data;
  logic [ADDR_W-1:0]  top_addr;
  logic               full;

  assign rd_key   = mem_rdata_i[KEY_W-1:0];
  assign rd_data  = mem_rdata_i[KEY_W+DATA_W-1:KEY_W];
  assign top_addr = ADDR_W'(fill_q - 1'b1);
  assign full     = (fill_q == FILL_W'(STACK_DEPTH));

  always_comb begin
    state_d     = state_q;
    fill_d      = fill_q;
    cnt_d       = cnt_q;
    mode_d      = mode_q;
    key_d       = key_q;
    data_d      = data_q;
    status_d    = status_q;
    okey_d      = okey_q;
    odata_d     = odata_q;
    in_ready_o  = 1'b0;
    mem_we_o    = 1'b0;
    mem_waddr_o = ADDR_W'(fill_q);
    mem_wdata_o = {data_q, key_q};
    mem_raddr_o = ADDR_W'(cnt_q + 1'b1);
    unique case (state_q)
      S_IDLE: begin
        in_ready_o = 1'b1;
        if (in_valid_i) begin
          mode_d   = mode_i;
          key_d    = key_i;
          data_d   = data_i;
          status_d = ST_OK;
          okey_d   = '0;
          odata_d  = '0;
          state_d  = S_RESP;
          case (mode_i) inside
            MODE_PUSH: begin
              if (fill_q == '0) begin
                mem_we_o    = 1'b1;
                mem_waddr_o = '0;
                mem_wdata_o = {data_i, key_i};
                fill_d      = fill_q + 1'b1;
              end else begin
                mem_raddr_o = '0;
                cnt_d       = '0;
                state_d     = S_SEARCH;
              end
            end
            MODE_POP, MODE_PEEK: begin
              if (fill_q == '0) begin
                status_d = ST_UNDER;
              end else begin
                mem_raddr_o = top_addr;
                state_d     = S_READ;
              end
            end
            default: begin
              status_d = ST_OK;
            end
          endcase
        end
      end
      S_SEARCH: begin
        if (rd_key == key_q) begin
          status_d = ST_DUP;
          state_d  = S_RESP;
        end else if (cnt_q == top_addr) begin
          if (full) begin
            status_d = ST_OVER;
          end else begin
            mem_we_o = 1'b1;
            fill_d   = fill_q + 1'b1;
          end
          state_d = S_RESP;
        end else begin
          cnt_d = cnt_q + 1'b1;
        end
      end
      S_READ: begin
        okey_d  = rd_key;
        odata_d = rd_data;
        if (mode_q == MODE_POP) begin
          fill_d = fill_q - 1'b1;
        end
        state_d = S_RESP;
      end
      S_RESP: begin
        if (res_ready_i) begin
          state_d = S_IDLE;
        end
      end
      default: begin
        state_d = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_IDLE;
      fill_q  <= '0;
    end else begin
      state_q <= state_d;
      fill_q  <= fill_d;
    end
  end

  always_ff @(posedge clk_i) begin
    cnt_q    <= cnt_d;
    mode_q   <= mode_d;
    key_q    <= key_d;
    data_q   <= data_d;
    status_q <= status_d;
    okey_q   <= okey_d;
    odata_q  <= odata_d;
  end

  assign res_valid_o       = (state_q == S_RESP);
  assign res_o.status      = status_q;
  assign res_o.out_key     = okey_q;
  assign res_o.out_data    = odata_q;
  assign res_o.is_empty    = (fill_q == '0);
  assign res_o.entry_count = COUNT_W'(fill_q);

endmodule

// ===== hw/rtl/unique_key_stack.sv =====
// Top level of the unique-key stack: stream ports, output register, the
// controller and the pair memory. Depends on uks_pkg, uks_mem and uks_ctrl.
//
//   channel  direction  tuser (low bit up)  tdata (low bit up)
//   s_       in         mode[1:0]           push_key[31:0], push_data[63:32]
//   m_       out        status[1:0]         out_key[31:0], out_data[63:32],
//                                           is_empty[64], entry_count[69:65]
//
// A push onto a non-empty stack searches the stored keys from the bottom up, one memory
// read of a stored key per cycle, until it meets a duplicate or the top entry; a push
// onto an empty stack, a pop, a peek and the unused mode need no search.
// The next word can be accepted in the cycle after the result register is loaded.
// Reset empties the stack at once; the memory contents are not cleared.
// One word is worked on at a time; the next word is accepted while a result
// waits in the output register, and a stalled output holds its word.
module unique_key_stack #(
  parameter int unsigned STACK_DEPTH = uks_pkg::DEF_STACK_DEPTH
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        s_tvalid_i,
  output logic        s_tready_o,
  input  logic [63:0] s_tdata_i,  // push_key[31:0], push_data[63:32]
  input  logic [1:0]  s_tuser_i,  // mode[1:0]
  output logic        m_tvalid_o,
  input  logic        m_tready_i,
  output logic [71:0] m_tdata_o,  // out_key, out_data, is_empty, entry_count, zero pad
  output logic [1:0]  m_tuser_o   // status[1:0]
);
  import uks_pkg::*;

  localparam int unsigned ADDR_W = $clog2(STACK_DEPTH);
  localparam int unsigned FILL_W = $clog2(STACK_DEPTH + 1);
  localparam int unsigned WORD_W = KEY_W + DATA_W;

  logic              res_valid;
  logic              res_ready;
  res_t              res;
  logic              mem_we;
  logic [ADDR_W-1:0] mem_waddr;
  logic [WORD_W-1:0] mem_wdata;
  logic [ADDR_W-1:0] mem_raddr;
  logic [WORD_W-1:0] mem_rdata;

  logic              out_valid_q, out_valid_d;
  res_t              out_q, out_d;

  uks_ctrl #(
    .STACK_DEPTH (STACK_DEPTH),
    .ADDR_W      (ADDR_W),
    .FILL_W      (FILL_W)
  ) u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (s_tvalid_i),
    .in_ready_o  (s_tready_o),
    .mode_i      (s_tuser_i),
    .key_i       (s_tdata_i[KEY_W-1:0]),
    .data_i      (s_tdata_i[WORD_W-1:KEY_W]),
    .res_valid_o (res_valid),
    .res_ready_i (res_ready),
    .res_o       (res),
    .mem_we_o    (mem_we),
    .mem_waddr_o (mem_waddr),
    .mem_wdata_o (mem_wdata),
    .mem_raddr_o (mem_raddr),
    .mem_rdata_i (mem_rdata)
  );

  uks_mem #(
    .DEPTH  (STACK_DEPTH),
    .ADDR_W (ADDR_W),
    .WORD_W (WORD_W)
  ) u_mem (
    .clk_i   (clk_i),
    .we_i    (mem_we),
    .waddr_i (mem_waddr),
    .wdata_i (mem_wdata),
    .raddr_i (mem_raddr),
    .rdata_o (mem_rdata)
  );

  assign res_ready = !out_valid_q || m_tready_i;

  always_comb begin
    out_valid_d = out_valid_q;
    out_d       = out_q;
    if (m_tready_i) begin
      out_valid_d = 1'b0;
    end
    if (res_valid && res_ready) begin
      out_valid_d = 1'b1;
      out_d       = res;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else begin
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    out_q <= out_d;
  end

  assign m_tvalid_o = out_valid_q;
  assign m_tuser_o  = out_q.status;
  assign m_tdata_o  = {2'b00, out_q.entry_count, out_q.is_empty, out_q.out_data, out_q.out_key};

`ifndef SYNTHESIS
  a_underflow_empty: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (m_tvalid_o && (m_tuser_o == ST_UNDER)) |-> m_tdata_o[64])
    else $error("underflow reported on a non-empty stack");

  a_overflow_full: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (m_tvalid_o && (m_tuser_o == ST_OVER)) |-> (m_tdata_o[69:65] == COUNT_W'(STACK_DEPTH)))
    else $error("overflow reported on a stack that is not full");

  a_one_at_a_time: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (s_tvalid_i && s_tready_o) |-> !res_valid)
    else $error("word accepted while a result is pending in the controller");
`endif

endmodule

// ===== tb/tb_top.sv =====
`timescale 1ns / 1ps
// Self-checking testbench for unique_key_stack: a directed table, then random words of all
// four modes checked against a behavioral LIFO model. Depends on uks_pkg and the RTL.
module tb_top;
  import uks_pkg::*;

  localparam int unsigned DEPTH          = DEF_STACK_DEPTH;
  localparam mode_t       MODE_SPARE     = 2'd3;
  localparam int          N_RANDOM       = 1500;
  localparam int          PHASE_LEN      = 500;
  localparam int          BIAS_RUN       = 40;
  localparam int          DRAIN_CYCLES   = 40;
  localparam int          WATCHDOG_LIMIT = 5000;
  localparam int          DIR_ROWS       = 25;

  typedef struct packed {
    mode_t              mode;
    logic [KEY_W-1:0]   key;
    logic [DATA_W-1:0]  data;
    logic               typed;
    status_e            st;
    logic [KEY_W-1:0]   rkey;
    logic [DATA_W-1:0]  rdata;
    logic               empty;
    logic [COUNT_W-1:0] count;
  } dir_row_t;

  logic        clk_i = 1'b0;
  logic        rst_ni;
  logic        s_tvalid_i;
  logic        s_tready_o;
  logic [63:0] s_tdata_i;   // push_key[31:0], push_data[63:32]
  logic [1:0]  s_tuser_i;   // mode[1:0]
  logic        m_tvalid_o;
  logic        m_tready_i;
  logic [71:0] m_tdata_o;   // out_key, out_data, is_empty, entry_count, zero pad
  logic [1:0]  m_tuser_o;   // status[1:0]

  logic [KEY_W-1:0]  stk_keys [DEPTH];
  logic [DATA_W-1:0] stk_vals [DEPTH];
  int unsigned       stk_fill;
  int unsigned       deepest;
  int                status_cnt [4];
  res_t              pending_res [$];
  int                src_idle_pct;
  int                snk_idle_pct;
  int                words_sent;
  int                results_seen;
  int                err_cnt;
  int                stall_cycles;

  // Rows: mode, key, data, typed, status, out_key, out_data, is_empty, entry_count.
  dir_row_t dir_tbl [DIR_ROWS] = '{
    '{MODE_POP,   32'h0,        32'h0,        1'b1, ST_UNDER, 32'h0, 32'h0, 1'b1, 5'd0},
    '{MODE_PEEK,  32'hFFFFFFFF, 32'hFFFFFFFF, 1'b1, ST_UNDER, 32'h0, 32'h0, 1'b1, 5'd0},
    '{MODE_SPARE, 32'hA5A5A5A5, 32'h5A5A5A5A, 1'b1, ST_OK,    32'h0, 32'h0, 1'b1, 5'd0},
    '{MODE_PUSH,  32'h80000000, 32'h7FFFFFFF, 1'b1, ST_OK,    32'h0, 32'h0, 1'b0, 5'd1},
    '{MODE_PUSH,  32'h80000000, 32'h00000001, 1'b1, ST_DUP,   32'h0, 32'h0, 1'b0, 5'd1},
    '{MODE_PEEK,  32'h0,        32'h0,        1'b1, ST_OK,
      32'h80000000, 32'h7FFFFFFF, 1'b0, 5'd1},
    '{MODE_PUSH,  32'h7FFFFFFF, 32'h80000000, 1'b0, ST_OK,    32'h0, 32'h0, 1'b0, 5'd0},
    '{MODE_PUSH,  32'h00000000, 32'hFFFFFFFF, 1'b0, ST_OK,    32'h0, 32'h0, 1'b0, 5'd0},
    '{MODE_PUSH,  32'hFFFFFFFF, 32'h00000000, 1'b0, ST_OK,    32'h0, 32'h0, 1'b0, 5'd0},
    '{MODE_PUSH,  32'h00000001, 32'h00000101, 1'b0, ST_OK,    32'h0, 32'h0, 1'b0, 5'd0},
    '{MODE_PUSH,  32'h00000002, 32'h00000102, 1'b0, ST_OK,    32'h0, 32'h0, 1'b0, 5'd0},
    '{MODE_PUSH,  32'h00000003, 32'h00000103, 1'b0, ST_OK,    32'h0, 32'h0, 1'b0, 5'd0},
    '{MODE_PUSH,  32'h00000004, 32'h00000104, 1'b0, ST_OK,    32'h0, 32'h0, 1'b0, 5'd0},
    '{MODE_PUSH,  32'h00000005, 32'h00000105, 1'b0, ST_OK,    32'h0, 32'h0, 1'b0, 5'd0},
    '{MODE_PUSH,  32'h00000006, 32'h00000106, 1'b0, ST_OK,    32'h0, 32'h0, 1'b0, 5'd0},
    '{MODE_PUSH,  32'h00000007, 32'h00000107, 1'b0, ST_OK,    32'h0, 32'h0, 1'b0, 5'd0},
    '{MODE_PUSH,  32'h00000008, 32'h00000108, 1'b0, ST_OK,    32'h0, 32'h0, 1'b0, 5'd0},
    '{MODE_PUSH,  32'h00000009, 32'h00000109, 1'b0, ST_OK,    32'h0, 32'h0, 1'b0, 5'd0},
    '{MODE_PUSH,  32'h0000000A, 32'h0000010A, 1'b0, ST_OK,    32'h0, 32'h0, 1'b0, 5'd0},
    '{MODE_PUSH,  32'h0000000B, 32'h0000010B, 1'b0, ST_OK,    32'h0, 32'h0, 1'b0, 5'd0},
    '{MODE_PUSH,  32'h0000000C, 32'h0000010C, 1'b0, ST_OK,    32'h0, 32'h0, 1'b0, 5'd0},
    '{MODE_PUSH,  32'h80000000, 32'h12345678, 1'b1, ST_DUP,   32'h0, 32'h0, 1'b0, 5'd16},
    '{MODE_PUSH,  32'h76543210, 32'h00000001, 1'b1, ST_OVER,  32'h0, 32'h0, 1'b0, 5'd16},
    '{MODE_POP,   32'h0,        32'h0,        1'b0, ST_OK,    32'h0, 32'h0, 1'b0, 5'd0},
    '{MODE_SPARE, 32'hFFFFFFFF, 32'hFFFFFFFF, 1'b0, ST_OK,    32'h0, 32'h0, 1'b0, 5'd0}
  };

  unique_key_stack #(
    .STACK_DEPTH(DEPTH)
  ) i_dut (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .s_tvalid_i(s_tvalid_i),
    .s_tready_o(s_tready_o),
    .s_tdata_i (s_tdata_i),
    .s_tuser_i (s_tuser_i),
    .m_tvalid_o(m_tvalid_o),
    .m_tready_i(m_tready_i),
    .m_tdata_o (m_tdata_o),
    .m_tuser_o (m_tuser_o)
  );

  always begin
    #5 clk_i = 1'b1;
    #5 clk_i = 1'b0;
  end

  // Applies one word to the model stack and returns the result it produces.
  function automatic res_t stack_step(mode_t mode, logic [KEY_W-1:0] key,
                                      logic [DATA_W-1:0] data);
    res_t r;
    bit   hit;
    r   = '0;
    hit = 1'b0;
    case (mode)
      MODE_PUSH: begin
        for (int i = 0; i < stk_fill; i++) begin
          if (stk_keys[i] == key) hit = 1'b1;
        end
        if (hit) begin
          r.status = ST_DUP;
        end else if (stk_fill >= DEPTH) begin
          r.status = ST_OVER;
        end else begin
          stk_keys[stk_fill] = key;
          stk_vals[stk_fill] = data;
          stk_fill++;
        end
      end
      MODE_POP, MODE_PEEK: begin
        if (stk_fill == 0) begin
          r.status = ST_UNDER;
        end else begin
          r.out_key  = stk_keys[stk_fill-1];
          r.out_data = stk_vals[stk_fill-1];
          if (mode == MODE_POP) stk_fill--;
        end
      end
      default: begin
      end
    endcase
    r.is_empty    = (stk_fill == 0);
    r.entry_count = COUNT_W'(stk_fill);
    if (stk_fill > deepest) deepest = stk_fill;
    status_cnt[r.status]++;
    return r;
  endfunction

  // Mostly fresh random keys; about a third repeat a key that is on the stack.
  function automatic logic [KEY_W-1:0] pick_key();
    if (stk_fill != 0 && $urandom_range(99) < 35) return stk_keys[$urandom_range(stk_fill-1)];
    return $urandom();
  endfunction

  task automatic flag_error(string msg);
    err_cnt++;
    if (err_cnt <= 10) $display("ERROR at %0t: %s", $realtime, msg);
  endtask

  task automatic send_word(mode_t mode, logic [KEY_W-1:0] key, logic [DATA_W-1:0] data,
                           bit typed, res_t want);
    res_t pred;
    while ($urandom_range(99) < src_idle_pct) begin
      s_tvalid_i <= 1'b0;
      @(negedge clk_i);
    end
    s_tvalid_i <= 1'b1;
    s_tuser_i  <= mode;
    s_tdata_i  <= {data, key};
    do @(posedge clk_i); while (!s_tready_o);
    pred = stack_step(mode, key, data);
    pending_res.push_back(typed ? want : pred);
    words_sent++;
    @(negedge clk_i);
  endtask

  always @(negedge clk_i) begin
    m_tready_i <= ($urandom_range(99) >= snk_idle_pct);
  end

  always @(posedge clk_i) begin : result_check
    res_t got;
    res_t want;
    if (rst_ni && m_tvalid_o && m_tready_i) begin
      got.status      = status_e'(m_tuser_o);
      got.out_key     = m_tdata_o[31:0];
      got.out_data    = m_tdata_o[63:32];
      got.is_empty    = m_tdata_o[64];
      got.entry_count = m_tdata_o[69:65];
      results_seen++;
      if (pending_res.size() == 0) begin
        flag_error($sformatf("result with none expected: st=%0d key=%h data=%h",
                             got.status, got.out_key, got.out_data));
      end else begin
        want = pending_res.pop_front();
        if (got.status !== want.status || got.out_key !== want.out_key ||
            got.out_data !== want.out_data || got.is_empty !== want.is_empty ||
            got.entry_count !== want.entry_count) begin
          flag_error($sformatf({"result %0d: expected st=%0d key=%h data=%h empty=%b ",
                                "count=%0d, got st=%0d key=%h data=%h empty=%b count=%0d"},
                               results_seen, want.status, want.out_key, want.out_data,
                               want.is_empty, want.entry_count, got.status, got.out_key,
                               got.out_data, got.is_empty, got.entry_count));
        end
      end
    end
  end

  always @(posedge clk_i) begin
    if ((s_tvalid_i && s_tready_o) || (m_tvalid_o && m_tready_i)) begin
      stall_cycles = 0;
    end else begin
      stall_cycles++;
    end
    if (stall_cycles >= WATCHDOG_LIMIT) begin
      $display("Timeout: no word moved for %0d cycles.", WATCHDOG_LIMIT);
      $display("TEST FAILED");
      $finish;
    end
  end

  initial begin
    res_t        want;
    mode_t       mode;
    int unsigned roll;
    bit          filling;
    s_tvalid_i   = 1'b0;
    s_tdata_i    = '0;
    s_tuser_i    = '0;
    rst_ni       = 1'b0;
    stk_fill     = 0;
    deepest      = 0;
    status_cnt   = '{default: 0};
    words_sent   = 0;
    src_idle_pct = 36;
    snk_idle_pct = 69;
    repeat (8) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni <= 1'b1;
    @(negedge clk_i);

    foreach (dir_tbl[i]) begin
      want.status      = dir_tbl[i].st;
      want.out_key     = dir_tbl[i].rkey;
      want.out_data    = dir_tbl[i].rdata;
      want.is_empty    = dir_tbl[i].empty;
      want.entry_count = dir_tbl[i].count;
      send_word(dir_tbl[i].mode, dir_tbl[i].key, dir_tbl[i].data, dir_tbl[i].typed, want);
    end

    // Runs alternate between filling and draining so that both full and empty recur.
    for (int n = 0; n < N_RANDOM; n++) begin
      if (n == PHASE_LEN) begin
        src_idle_pct = 69;
        snk_idle_pct = 36;
      end else if (n == 2 * PHASE_LEN) begin
        src_idle_pct = 0;
        snk_idle_pct = 0;
      end
      filling = ((n / BIAS_RUN) % 2 == 0);
      roll    = $urandom_range(99);
      if (roll < 3)                     mode = MODE_SPARE;
      else if (roll < (filling ? 68 : 28)) mode = MODE_PUSH;
      else if (roll < (filling ? 86 : 83)) mode = MODE_POP;
      else                              mode = MODE_PEEK;
      send_word(mode, pick_key(), $urandom(), 1'b0, want);
    end
    s_tvalid_i <= 1'b0;

    while (pending_res.size() != 0) @(posedge clk_i);
    repeat (DRAIN_CYCLES) @(posedge clk_i);

    $display("Sent %0d words and checked %0d results, %0d mismatches.",
             words_sent, results_seen, err_cnt);
    $display("Status mix: %0d ok, %0d duplicate, %0d underflow, %0d overflow; deepest fill %0d.",
             status_cnt[ST_OK], status_cnt[ST_DUP], status_cnt[ST_UNDER],
             status_cnt[ST_OVER], deepest);
    if (err_cnt == 0) begin
      $display("TEST PASSED");
    end else begin
      $display("TEST FAILED");
    end
    $finish;
  end

endmodule
